// ===== rtl/waypoint_linear_densifier_defines.svh =====
// Assertion helpers for the waypoint densifier.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef WAYPOINT_LINEAR_DENSIFIER_DEFINES_SVH
`define WAYPOINT_LINEAR_DENSIFIER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WLD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wld_pkg.sv =====
`default_nettype none

package wld_pkg;

  // Coordinate and register widths
  localparam int unsigned CoordW       = 32;
  localparam int unsigned ResW         = 25;
  localparam int unsigned MaxPointsDef = 64;
  localparam logic [ResW-1:0] ResReset = 25'd3277;

  // |cur - prev| needs one bit more than a coordinate
  localparam int unsigned MagW  = CoordW + 1;
  // dx^2 + dy^2
  localparam int unsigned SqW   = 2 * MagW;
  // integer square root of the squared length
  localparam int unsigned RootW = MagW;
  // compare/subtract width, covers the root's partial remainder
  localparam int unsigned AluW  = RootW + 4;

  // One emitted point
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              last;
  } wld_item_t;

  // Operands of the shared arithmetic unit
  typedef struct packed {
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
    logic [MagW-1:0] ma;
    logic [MagW-1:0] mb;
  } wld_alu_req_t;

  // Results of the shared arithmetic unit
  typedef struct packed {
    logic [AluW-1:0] diff;
    logic            ge;
    logic [SqW-1:0]  prod;
  } wld_alu_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/wld_alu.sv =====
`default_nettype none

// Shared arithmetic unit: one compare-subtract and one squaring multiplier.
module wld_alu (
  input  wld_pkg::wld_alu_req_t req_i,
  output wld_pkg::wld_alu_rsp_t rsp_o
);
  import wld_pkg::*;

  logic [AluW:0]  sub;
  logic [SqW-1:0] mul;

  // a - b with borrow out; no borrow means a >= b
  assign sub        = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign rsp_o.diff = sub[AluW-1:0];
  assign rsp_o.ge   = ~sub[AluW];

  // product is registered by the sequencer
  assign mul        = req_i.ma * req_i.mb;
  assign rsp_o.prod = mul;

endmodule

`default_nettype wire

// ===== rtl/wld_core.sv =====
`default_nettype none

// Sequencer and datapath: squares, root, step count, step division, emission.
module wld_core #(
  parameter int unsigned MAX_POINTS = wld_pkg::MaxPointsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [wld_pkg::CoordW-1:0]  in_x_i,
  input  logic [wld_pkg::CoordW-1:0]  in_y_i,
  input  logic                        in_start_i,
  input  logic [wld_pkg::ResW-1:0]    res_i,
  output logic                        item_valid_o,
  input  logic                        item_ready_i,
  output wld_pkg::wld_item_t          item_o
);
  import wld_pkg::*;

  localparam int unsigned NW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned RemW = NW + 2;
  localparam int unsigned CntW = $clog2(MagW);
  localparam logic [NW-1:0] NMax = NW'(MAX_POINTS);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SSqX  = 4'd1;
  localparam logic [3:0] SSqY  = 4'd2;
  localparam logic [3:0] SSum  = 4'd3;
  localparam logic [3:0] SSqrt = 4'd4;
  localparam logic [3:0] SNDiv = 4'd5;
  localparam logic [3:0] SNSet = 4'd6;
  localparam logic [3:0] SXDiv = 4'd7;
  localparam logic [3:0] SYDiv = 4'd8;
  localparam logic [3:0] SEmit = 4'd9;

  logic [3:0]        state_q, state_d;
  logic              have_prev_q, have_prev_d;
  logic [CoordW-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [CoordW-1:0] base_x_q, base_x_d, base_y_q, base_y_d;
  logic [MagW-1:0]   ax_q, ax_d, ay_q, ay_d;
  logic              negx_q, negx_d, negy_q, negy_d;
  logic [SqW-1:0]    rad_q, rad_d, prod_q, prod_d;
  logic [AluW-1:0]   rem_q, rem_d;
  logic [RootW-1:0]  root_q, root_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [NW:0]       nq_q, nq_d;
  logic [NW-1:0]     n_q, n_d;
  logic [MagW-1:0]   div_q, div_d;
  logic [MagW-1:0]   stepx_q, stepx_d, stepy_q, stepy_d;
  logic [NW-1:0]     rstx_q, rstx_d, rsty_q, rsty_d;
  logic [MagW-1:0]   accx_q, accx_d, accy_q, accy_d;
  logic [RemW-1:0]   rx_q, rx_d, ry_q, ry_d;
  logic [NW-1:0]     idx_q, idx_d;

  wld_alu_req_t      alu_req;
  wld_alu_rsp_t      alu_rsp;
  logic [AluW-1:0]   rem_sel;
  logic [MagW-1:0]   dx, dy;
  logic [RootW-1:0]  root_next;
  logic [MagW-1:0]   quo_next;
  logic [NW-1:0]     n_sat;
  logic [RemW-1:0]   two_n, sum_x, sum_y;
  logic              wrap_x, wrap_y;

  wld_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Operand selection for the shared unit
  always_comb begin
    alu_req    = '0;
    alu_req.ma = ax_q;
    alu_req.mb = ax_q;
    unique case (state_q)
      SSqY: begin
        alu_req.ma = ay_q;
        alu_req.mb = ay_q;
      end
      // bit pair of the radicand against 4*root + 1
      SSqrt: begin
        alu_req.a = {rem_q[AluW-3:0], rad_q[SqW-1 -: 2]};
        alu_req.b = AluW'({root_q, 2'b01});
      end
      // step count: root against resolution << k
      SNDiv: begin
        alu_req.a = rem_q;
        alu_req.b = AluW'(res_i) << cnt_q;
      end
      // long division of |d| by n, one quotient bit per step
      SXDiv, SYDiv: begin
        alu_req.a = {rem_q[AluW-2:0], div_q[MagW-1]};
        alu_req.b = AluW'(n_q);
      end
      default: ;
    endcase
  end

  assign rem_sel   = alu_rsp.ge ? alu_rsp.diff : alu_req.a;
  assign root_next = {root_q[RootW-2:0], alu_rsp.ge};
  assign quo_next  = {div_q[MagW-2:0], alu_rsp.ge};

  // Segment deltas against the stored waypoint
  assign dx = {in_x_i[CoordW-1], in_x_i} - {prev_x_q[CoordW-1], prev_x_q};
  assign dy = {in_y_i[CoordW-1], in_y_i} - {prev_y_q[CoordW-1], prev_y_q};

  // Saturate the step count
  assign n_sat = (nq_q[NW] || (nq_q[NW-1:0] > NMax)) ? NMax : nq_q[NW-1:0];

  // Rounded offsets advance by |d| / n, remainder kept against 2n
  assign two_n  = RemW'({n_q, 1'b0});
  assign sum_x  = rx_q + RemW'({rstx_q, 1'b0});
  assign sum_y  = ry_q + RemW'({rsty_q, 1'b0});
  assign wrap_x = (sum_x >= two_n);
  assign wrap_y = (sum_y >= two_n);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    have_prev_d = have_prev_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    base_x_d    = base_x_q;
    base_y_d    = base_y_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    negx_d      = negx_q;
    negy_d      = negy_q;
    rad_d       = rad_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    root_d      = root_q;
    cnt_d       = cnt_q;
    nq_d        = nq_q;
    n_d         = n_q;
    div_d       = div_q;
    stepx_d     = stepx_q;
    stepy_d     = stepy_q;
    rstx_d      = rstx_q;
    rsty_d      = rsty_q;
    accx_d      = accx_q;
    accy_d      = accy_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    idx_d       = idx_q;

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          prev_x_d    = in_x_i;
          prev_y_d    = in_y_i;
          have_prev_d = 1'b1;
          base_x_d    = prev_x_q;
          base_y_d    = prev_y_q;
          negx_d      = dx[MagW-1];
          negy_d      = dy[MagW-1];
          ax_d        = dx[MagW-1] ? (~dx + MagW'(1)) : dx;
          ay_d        = dy[MagW-1] ? (~dy + MagW'(1)) : dy;
          if (!in_start_i && have_prev_q) begin
            state_d = SSqX;
          end
        end
      end
      SSqX: begin
        rad_d   = alu_rsp.prod;
        state_d = SSqY;
      end
      SSqY: begin
        prod_d  = alu_rsp.prod;
        state_d = SSum;
      end
      SSum: begin
        rad_d   = rad_q + prod_q;
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = CntW'(RootW - 1);
        state_d = SSqrt;
      end
      SSqrt: begin
        rad_d  = rad_q << 2;
        rem_d  = rem_sel;
        root_d = root_next;
        cnt_d  = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          rem_d   = AluW'(root_next);
          nq_d    = '0;
          cnt_d   = CntW'(NW);
          state_d = SNDiv;
        end
      end
      SNDiv: begin
        nq_d  = {nq_q[NW-1:0], alu_rsp.ge};
        rem_d = rem_sel;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = SNSet;
        end
      end
      SNSet: begin
        n_d = n_sat;
        if (n_sat == '0) begin
          state_d = SIdle;
        end else begin
          rem_d   = '0;
          div_d   = ax_q;
          cnt_d   = CntW'(MagW - 1);
          state_d = SXDiv;
        end
      end
      SXDiv: begin
        div_d = quo_next;
        rem_d = rem_sel;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          stepx_d = quo_next;
          rstx_d  = NW'(rem_sel);
          rem_d   = '0;
          div_d   = ay_q;
          cnt_d   = CntW'(MagW - 1);
          state_d = SYDiv;
        end
      end
      SYDiv: begin
        div_d = quo_next;
        rem_d = rem_sel;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          stepy_d = quo_next;
          rsty_d  = NW'(rem_sel);
          accx_d  = '0;
          accy_d  = '0;
          rx_d    = RemW'(n_q);
          ry_d    = RemW'(n_q);
          idx_d   = '0;
          state_d = SEmit;
        end
      end
      SEmit: begin
        if (item_ready_i) begin
          rx_d   = wrap_x ? (sum_x - two_n) : sum_x;
          ry_d   = wrap_y ? (sum_y - two_n) : sum_y;
          accx_d = accx_q + stepx_q + MagW'(wrap_x);
          accy_d = accy_q + stepy_q + MagW'(wrap_y);
          idx_d  = idx_q + NW'(1);
          if (item_o.last) begin
            state_d = SIdle;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      have_prev_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prev_x_q <= prev_x_d;
    prev_y_q <= prev_y_d;
    base_x_q <= base_x_d;
    base_y_q <= base_y_d;
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    negx_q   <= negx_d;
    negy_q   <= negy_d;
    rad_q    <= rad_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    cnt_q    <= cnt_d;
    nq_q     <= nq_d;
    n_q      <= n_d;
    div_q    <= div_d;
    stepx_q  <= stepx_d;
    stepy_q  <= stepy_d;
    rstx_q   <= rstx_d;
    rsty_q   <= rsty_d;
    accx_q   <= accx_d;
    accy_q   <= accy_d;
    rx_q     <= rx_d;
    ry_q     <= ry_d;
    idx_q    <= idx_d;
  end

  // Emitted point: base plus or minus the rounded offset
  assign in_ready_o   = (state_q == SIdle);
  assign item_valid_o = (state_q == SEmit);
  assign item_o.x     = negx_q ? (base_x_q - accx_q[CoordW-1:0])
                               : (base_x_q + accx_q[CoordW-1:0]);
  assign item_o.y     = negy_q ? (base_y_q - accy_q[CoordW-1:0])
                               : (base_y_q + accy_q[CoordW-1:0]);
  assign item_o.last  = (({1'b0, idx_q} + (NW+1)'(1)) == {1'b0, n_q});

endmodule

`default_nettype wire

// ===== rtl/waypoint_linear_densifier.sv =====
// A path start, or a waypoint with none stored, is only stored and emits no points.
// Other waypoints pass through the squares, the root and the step count, then,
// if n > 0, the step division and the emission of n points.
// A new waypoint is taken only once the last one is done; one shared compare-subtract unit.
// Points leave through an output register, one per cycle when not stalled.
// Reset: no stored waypoint, grid_resolution = 3277, output empty.
`default_nettype none
`include "waypoint_linear_densifier_defines.svh"

module waypoint_linear_densifier #(
  parameter int unsigned MAX_POINTS = wld_pkg::MaxPointsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // waypoint stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [2*wld_pkg::CoordW-1:0]  s_axis_tdata,  // point_x, point_y
  input  logic                          s_axis_tuser,  // path_start
  // point stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [2*wld_pkg::CoordW-1:0]  m_axis_tdata,  // out_x, out_y
  output logic                          m_axis_tlast,  // last_of_segment
  // grid_resolution write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wld_pkg::ResW-1:0]      cfg_data_i
);
  import wld_pkg::*;

  logic [ResW-1:0] res_q;
  logic [ResW-1:0] res_eff;
  logic            item_valid;
  logic            item_ready;
  wld_item_t       item;
  logic            out_vld_q;
  wld_item_t       out_q;

  // Resolution register; zero behaves as one
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= ResReset;
    end else if (cfg_valid_i) begin
      res_q <= cfg_data_i;
    end
  end
  assign res_eff = (res_q == '0) ? ResW'(1) : res_q;

  wld_core #(
    .MAX_POINTS (MAX_POINTS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_x_i       (s_axis_tdata[CoordW-1:0]),
    .in_y_i       (s_axis_tdata[2*CoordW-1:CoordW]),
    .in_start_i   (s_axis_tuser),
    .res_i        (res_eff),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // Output register
  assign item_ready = !out_vld_q || m_axis_tready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (item_valid && item_ready) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid && item_ready) begin
      out_q <= item;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.y, out_q.x};
  assign m_axis_tlast  = out_q.last;

  // Checks
  `WLD_ASSERT_SAME(a_emit_busy, item_valid, !s_axis_tready, "point emitted while accepting")
  `WLD_ASSERT_NEXT(a_start_idle, s_axis_tvalid && s_axis_tready && s_axis_tuser,
    s_axis_tready, "path start did not return to idle")
  `WLD_ASSERT_NEXT(a_last_idle, item_valid && item_ready && item.last,
    s_axis_tready, "segment end did not return to idle")

endmodule

`default_nettype wire
